### rtl/core/ksbc_pkg.sv
// Package for the keyed substitution-box block cipher.
// Holds codes, sizes, command/status structs and the CRC, mask and permutation functions.
// Depends on nothing.
package ksbc_pkg;

  localparam int KEY_MAX    = 256;
  localparam int BANKS      = 16;
  localparam int BANK_DEPTH = 8192;
  localparam int BANK_AW    = 13;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [6:0]  BIAS_TRY  = 7'd98;
  localparam logic [7:0]  LAST_SLOT = 8'd255;

  localparam logic CFG_BLOCK_MODE = 1'b0;
  localparam logic CFG_NUM_ROUNDS = 1'b1;

  localparam logic [1:0] KIND_KEY = 2'd0;
  localparam logic [1:0] KIND_ENC = 2'd1;
  localparam logic [1:0] KIND_DEC = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ROUND = 2'd1;
  localparam logic [1:0] ST_NOT_KEYED = 2'd2;
  localparam logic [1:0] ST_KEY_LONG  = 2'd3;

  typedef logic [15:0][7:0] blk_t;

  typedef struct packed {
    logic       accept;
    logic       sched_init;
    logic       key_clear;
    logic       box_init;
    logic       draw_init;
    logic       crc_key;
    logic       crc_lo;
    logic       crc_hi;
    logic       eval;
    logic       walk;
    logic       inv_step;
    logic       set_valid;
    logic       apply;
    logic       emit;
    logic       emit_data;
    logic [1:0] emit_status;
  } ksbc_cmd_t;

  typedef struct packed {
    logic sched_valid;
    logic rounds_bad;
    logic key_bad;
    logic n_zero;
    logic wrap;
    logic draw_ok;
    logic walk_found;
    logic box_last;
    logic k_end;
    logic round_last;
  } ksbc_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  // Smallest all-ones mask that covers n.
  function automatic logic [7:0] cover_mask(input logic [7:0] n);
    logic [7:0] m;
    m = n | (n >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    return m;
  endfunction

  // Output byte i takes bit b from byte i+b (forward) or i-b (reverse), modulo block size.
  function automatic blk_t permute(input blk_t x, input logic full, input logic rev);
    blk_t       y;
    logic [3:0] msk;
    logic [3:0] src;
    msk = full ? 4'd15 : 4'd7;
    for (int i = 0; i < 16; i++) begin
      for (int b = 0; b < 8; b++) begin
        src = rev ? 4'(i + 16 - b) : 4'(i + b);
        src = src & msk;
        y[i][b] = x[src][b];
      end
    end
    return y;
  endfunction

endpackage

### rtl/core/ksbc_dp.sv
// Datapath of the cipher: key store, CRC draw unit, slot walker, banked box memories,
// inverse builder and the round datapath. Uses ksbc_pkg; driven by ksbc_ctrl.
module ksbc_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ksbc_pkg::ksbc_cmd_t   cmd,
  output ksbc_pkg::ksbc_stat_t  stat,
  input  logic                  cfg_mode,
  input  logic [4:0]            cfg_rounds,
  input  logic [1:0]            in_kind,
  input  logic [7:0]            in_key_byte,
  input  logic                  in_key_last,
  input  logic [63:0]           in_block_hi,
  input  logic [63:0]           in_block_lo,
  output logic                  out_valid,
  output logic [63:0]           out_hi,
  output logic [63:0]           out_lo,
  output logic [1:0]            out_status
);
  import ksbc_pkg::*;

  logic [7:0]   key_mem [KEY_MAX];
  logic [7:0]   kq_r;
  logic [8:0]   klen_r, klen_s_r;
  logic         ovf_r;
  logic [7:0]   pos_r;
  logic [31:0]  crc_r;
  logic [6:0]   tries_r;
  logic [7:0]   n_r, p_r, wcnt_r;
  logic [255:0] filled_r;
  logic [4:0]   sr_r;
  logic [3:0]   sj_r;
  logic [8:0]   k_r;
  logic         svalid_r, smode_r;
  logic [4:0]   srounds_r;
  blk_t         x_r;
  logic [4:0]   rc_r;
  logic         dir_r;
  logic         out_valid_r;
  logic [63:0]  out_hi_r, out_lo_r;
  logic [1:0]   out_status_r;

  logic [6:0]   tries_nxt;
  logic [7:0]   draw_v;
  logic [7:0]   vmask;
  logic [3:0]   bs_last;
  logic         box_adv;
  blk_t         box_q, inv_q, sub_q;
  logic [BANK_AW-1:0] box_ra [BANKS];
  logic [BANK_AW-1:0] inv_ra [BANKS];

  assign bs_last = smode_r ? 4'd15 : 4'd7;

  always_comb begin
    vmask     = cover_mask(n_r);
    tries_nxt = (tries_r == BIAS_TRY) ? BIAS_TRY : tries_r + 7'd1;
    draw_v    = crc_r[7:0] & vmask;
    if (tries_nxt == BIAS_TRY && draw_v > n_r) begin
      draw_v = draw_v - n_r;
    end
  end

  assign stat.sched_valid = svalid_r;
  assign stat.rounds_bad  = smode_r ? (srounds_r < 5'd5 || srounds_r > 5'd15)
                                    : (srounds_r < 5'd3);
  assign stat.key_bad     = ovf_r || (klen_r == 9'd0);
  assign stat.n_zero      = (n_r == 8'd0);
  assign stat.wrap        = ({1'b0, pos_r} + 9'd1) >= klen_s_r;
  assign stat.draw_ok     = draw_v <= n_r;
  assign stat.walk_found  = !filled_r[p_r] && (wcnt_r == 8'd0);
  assign stat.box_last    = (sr_r == srounds_r - 5'd1) && (sj_r == bs_last);
  assign stat.k_end       = k_r[8];
  assign stat.round_last  = dir_r ? (rc_r == 5'd0) : (rc_r == srounds_r - 5'd1);

  // A box is finished when its last entry is placed, or when its inverse is written.
  assign box_adv = (cmd.walk && stat.walk_found && stat.n_zero) || (cmd.inv_step && k_r[8]);

  always_ff @(posedge clk) begin
    kq_r <= key_mem[pos_r];
    if (cmd.accept && in_kind == KIND_KEY && klen_r < 9'(KEY_MAX)) begin
      key_mem[klen_r[7:0]] <= in_key_byte;
    end
  end

  // Each byte position of the block owns one bank of each box memory.
  for (genvar g = 0; g < BANKS; g++) begin : g_bank
    logic [7:0] bmem [BANK_DEPTH];
    logic [7:0] imem [BANK_DEPTH];

    assign box_ra[g] = cmd.inv_step ? {sr_r, k_r[7:0]} : {rc_r, x_r[g]};
    assign inv_ra[g] = {rc_r, x_r[g]};

    always_ff @(posedge clk) begin
      if (cmd.walk && stat.walk_found && sj_r == 4'(g)) begin
        bmem[{sr_r, p_r}] <= n_r;
      end
      if (cmd.inv_step && k_r != 9'd0 && sj_r == 4'(g)) begin
        imem[{sr_r, box_q[sj_r]}] <= 8'(k_r - 9'd1);
      end
      box_q[g] <= bmem[box_ra[g]];
      inv_q[g] <= imem[inv_ra[g]];
    end
  end

  assign sub_q = dir_r ? inv_q : box_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r      <= '0;
      ovf_r       <= 1'b0;
      svalid_r    <= 1'b0;
      smode_r     <= 1'b1;
      srounds_r   <= 5'd10;
      crc_r       <= CRC_INIT;
      pos_r       <= '0;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.accept) begin
        if (in_kind == KIND_KEY) begin
          if (klen_r < 9'(KEY_MAX)) begin
            klen_r <= klen_r + 9'd1;
          end else begin
            ovf_r <= 1'b1;
          end
          if (in_key_last) begin
            smode_r   <= cfg_mode;
            srounds_r <= cfg_rounds;
          end
        end
      end
      if (cmd.key_clear) begin
        klen_r   <= '0;
        ovf_r    <= 1'b0;
        svalid_r <= 1'b0;
      end
      if (cmd.sched_init) begin
        klen_r   <= '0;
        ovf_r    <= 1'b0;
        svalid_r <= 1'b0;
        crc_r    <= CRC_INIT;
        pos_r    <= '0;
      end
      if (cmd.set_valid) begin
        svalid_r <= 1'b1;
      end
      if (cmd.box_init) begin
        filled_r <= '0;
      end
      if (cmd.crc_key) begin
        crc_r <= crc_byte(crc_r, kq_r);
        pos_r <= stat.wrap ? 8'd0 : pos_r + 8'd1;
      end
      if (cmd.crc_lo) begin
        crc_r <= crc_byte(crc_r, klen_s_r[7:0]);
      end
      if (cmd.crc_hi) begin
        crc_r <= crc_byte(crc_r, {7'd0, klen_s_r[8]});
      end
      if (cmd.walk && stat.walk_found) begin
        filled_r[p_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r   <= {in_block_hi, in_block_lo};
      dir_r <= (in_kind == KIND_DEC);
      rc_r  <= (in_kind == KIND_DEC) ? srounds_r - 5'd1 : 5'd0;
    end
    if (cmd.sched_init) begin
      klen_s_r <= klen_r;
      sr_r     <= '0;
      sj_r     <= '0;
      k_r      <= '0;
    end
    if (cmd.box_init) begin
      n_r <= LAST_SLOT;
    end
    if (cmd.draw_init) begin
      tries_r <= '0;
      p_r     <= '0;
      wcnt_r  <= '0;
    end
    if (cmd.eval) begin
      tries_r <= tries_nxt;
      p_r     <= '0;
      wcnt_r  <= draw_v;
    end
    if (cmd.walk) begin
      if (stat.walk_found) begin
        n_r <= n_r - 8'd1;
      end else begin
        p_r <= p_r + 8'd1;
        if (!filled_r[p_r]) begin
          wcnt_r <= wcnt_r - 8'd1;
        end
      end
    end
    if (cmd.inv_step) begin
      k_r <= k_r[8] ? 9'd0 : k_r + 9'd1;
    end
    if (box_adv) begin
      if (stat.box_last) begin
        sr_r <= '0;
        sj_r <= '0;
      end else if (sj_r == bs_last) begin
        sj_r <= '0;
        sr_r <= sr_r + 5'd1;
      end else begin
        sj_r <= sj_r + 4'd1;
      end
    end
    if (cmd.apply) begin
      x_r <= stat.round_last ? sub_q : permute(sub_q, smode_r, dir_r);
      if (!stat.round_last) begin
        rc_r <= dir_r ? rc_r - 5'd1 : rc_r + 5'd1;
      end
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_lo_r     <= cmd.emit_data ? sub_q[7:0] : 64'd0;
      out_hi_r     <= (cmd.emit_data && smode_r) ? sub_q[15:8] : 64'd0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hi     = out_hi_r;
  assign out_lo     = out_lo_r;
  assign out_status = out_status_r;

endmodule

### rtl/core/ksbc_ctrl.sv
// Controller state machine of the cipher: accepts transactions, sequences the key
// schedule and the rounds. Uses ksbc_pkg; commands ksbc_dp.
module ksbc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            in_kind,
  input  logic                  in_key_last,
  input  ksbc_pkg::ksbc_stat_t  stat,
  output ksbc_pkg::ksbc_cmd_t   cmd,
  output logic                  busy
);
  import ksbc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_KCHK, S_BOX, S_DRAW, S_RD, S_CRC, S_L0, S_L1,
    S_EVAL, S_WALK, S_INV, S_FIN, S_SUB, S_APPLY
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          priority if (in_kind == KIND_KEY) begin
            if (in_key_last) state_nxt = S_KCHK;
          end else if (in_kind == KIND_ENC || in_kind == KIND_DEC) begin
            if (stat.sched_valid) begin
              state_nxt = S_SUB;
            end else begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_NOT_KEYED;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_KCHK: begin
        priority if (stat.rounds_bad) begin
          cmd.key_clear   = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_BAD_ROUND;
          state_nxt       = S_IDLE;
        end else if (stat.key_bad) begin
          cmd.key_clear   = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_KEY_LONG;
          state_nxt       = S_IDLE;
        end else begin
          cmd.sched_init = 1'b1;
          state_nxt      = S_BOX;
        end
      end
      S_BOX: begin
        cmd.box_init = 1'b1;
        state_nxt    = S_DRAW;
      end
      S_DRAW: begin
        cmd.draw_init = 1'b1;
        state_nxt     = stat.n_zero ? S_WALK : S_RD;
      end
      S_RD: state_nxt = S_CRC;
      S_CRC: begin
        cmd.crc_key = 1'b1;
        state_nxt   = stat.wrap ? S_L0 : S_EVAL;
      end
      S_L0: begin
        cmd.crc_lo = 1'b1;
        state_nxt  = S_L1;
      end
      S_L1: begin
        cmd.crc_hi = 1'b1;
        state_nxt  = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.draw_ok ? S_WALK : S_RD;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_found) begin
          if (!stat.n_zero) state_nxt = S_DRAW;
          else if (stat.box_last) state_nxt = S_INV;
          else state_nxt = S_BOX;
        end
      end
      S_INV: begin
        cmd.inv_step = 1'b1;
        if (stat.k_end && stat.box_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.set_valid   = 1'b1;
        cmd.emit        = 1'b1;
        cmd.emit_status = ST_OK;
        state_nxt       = S_IDLE;
      end
      S_SUB: state_nxt = S_APPLY;
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (stat.round_last) begin
          cmd.emit        = 1'b1;
          cmd.emit_data   = 1'b1;
          cmd.emit_status = ST_OK;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_SUB;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/core/keyed_sbox_block_cipher.sv
// Top level of the keyed substitution-box block cipher: configuration registers and
// the controller/datapath pair. Uses ksbc_pkg, ksbc_ctrl and ksbc_dp.
//
// Usage. A transaction is taken when start is high and busy is low. Kind selects a key
// byte, an encrypt block or a decrypt block. Key bytes are stored in order; the byte
// flagged with in_key_last runs the key schedule, which builds one substitution box
// and its inverse per round and byte position, and then gives one result with status.
// A block gives one result after its R rounds: each round reads all byte boxes at once
// from sixteen memory banks into registers and then substitutes and, in all but the
// last round, permutes. No new transaction is taken while a block is in its rounds; the
// next one can be taken at the edge that ends the result's cycle. The key schedule is
// long and key dependent: each box entry but the last needs CRC draws over the key and
// a walk over up to 256 slots, one slot per cycle; inverse boxes are built entry by entry.
// Each result shows on out_hi, out_lo and out_status for one cycle with out_valid high;
// the receiver cannot stall it. The configuration channel is always ready; block_mode
// and num_rounds are taken when a key schedule starts. After reset the block is
// unkeyed, so blocks give a not-keyed status until a schedule succeeds.
module keyed_sbox_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_key_byte,
  input  logic        in_key_last,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  output logic        out_valid,
  output logic [63:0] out_hi,
  output logic [63:0] out_lo,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);
  import ksbc_pkg::*;

  logic       block_mode_r;
  logic [4:0] num_rounds_r;
  ksbc_cmd_t  cmd;
  ksbc_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_mode_r <= 1'b1;
      num_rounds_r <= 5'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLOCK_MODE: block_mode_r <= cfg_data[0];
        CFG_NUM_ROUNDS: num_rounds_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ksbc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_kind     (in_kind),
    .in_key_last (in_key_last),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  ksbc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_mode    (block_mode_r),
    .cfg_rounds  (num_rounds_r),
    .in_kind     (in_kind),
    .in_key_byte (in_key_byte),
    .in_key_last (in_key_last),
    .in_block_hi (in_block_hi),
    .in_block_lo (in_block_lo),
    .out_valid   (out_valid),
    .out_hi      (out_hi),
    .out_lo      (out_lo),
    .out_status  (out_status)
  );

endmodule
